FILE: src/nfd_pkg.sv
// shared constants and controller/datapath interface types for the derivative block
`timescale 1ns / 1ps

package nfd_pkg;

    localparam int TIME_BITS  = 32;
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DERIV_BITS = 48;

    // signed differences carry one extra bit
    localparam int DY_BITS    = VALUE_BITS + 1;
    localparam int DT_BITS    = TIME_BITS + 1;
    // dividend is |dy| scaled by the fraction bits, quotient shares its register
    localparam int QUO_BITS   = DY_BITS + FRAC_BITS;
    localparam int CNT_BITS   = $clog2(QUO_BITS);

    // reference sample for the difference
    localparam logic REF_NEWER = 1'b0;
    localparam logic REF_OLDER = 1'b1;

    typedef logic [1:0] out_sel_t;

    // which result is loaded into the output register
    localparam out_sel_t OUT_HELD   = 2'd0;
    localparam out_sel_t OUT_FINAL  = 2'd1;
    localparam out_sel_t OUT_SINGLE = 2'd2;

    typedef struct packed {
        logic     capture;
        logic     diff;
        logic     ref_sel;
        logic     abs_load;
        logic     div_step;
        logic     out_load;
        out_sel_t out_sel;
        logic     shift;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } status_t;

endpackage

FILE: src/nfd_dpath.sv
// datapath: sample history, differences, bit-serial divider and output register
`timescale 1ns / 1ps

module nfd_dpath
    import nfd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output status_t                      status,
    input  logic [TIME_BITS-1:0]         time_stamp,
    input  logic signed [VALUE_BITS-1:0] sample_value,
    input  logic                         last_sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] value_echo,
    output logic signed [DERIV_BITS-1:0] derivative,
    output logic                         div_error,
    output logic                         last_result
);

    logic [TIME_BITS-1:0]         in_t_reg;
    logic signed [VALUE_BITS-1:0] in_v_reg;
    logic                         in_last_reg;
    logic [TIME_BITS-1:0]         older_t_reg;
    logic signed [VALUE_BITS-1:0] older_v_reg;
    logic [TIME_BITS-1:0]         newer_t_reg;
    logic signed [VALUE_BITS-1:0] newer_v_reg;

    logic signed [DY_BITS-1:0]    dy_reg;
    logic signed [DT_BITS-1:0]    dt_reg;
    logic                         neg_reg;
    logic                         zero_reg;
    logic [DT_BITS-1:0]           dvs_reg;
    logic [DT_BITS-1:0]           rem_reg;
    logic [QUO_BITS-1:0]          quo_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [DERIV_BITS-1:0] deriv_reg;
    logic                         err_reg;
    logic                         last_reg;

    logic [TIME_BITS-1:0]         ref_t;
    logic signed [VALUE_BITS-1:0] ref_v;
    logic [DY_BITS-1:0]           ady;
    logic [DT_BITS-1:0]           adt;
    logic [DT_BITS:0]             shifted;
    logic [DT_BITS+1:0]           trial;
    logic                         fits;
    logic                         over;
    logic [DERIV_BITS-1:0]        mag;
    logic signed [DERIV_BITS-1:0] deriv_val;

    assign ref_t = (cmd.ref_sel == REF_OLDER) ? older_t_reg : newer_t_reg;
    assign ref_v = (cmd.ref_sel == REF_OLDER) ? older_v_reg : newer_v_reg;

    assign ady = dy_reg[DY_BITS-1] ? DY_BITS'(-dy_reg) : DY_BITS'(dy_reg);
    assign adt = dt_reg[DT_BITS-1] ? DT_BITS'(-dt_reg) : DT_BITS'(dt_reg);

    // restoring step: bring down the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[QUO_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~trial[DT_BITS+1];

    // clamp to the 48-bit range, the negative end is one further out
    always_comb
    begin
        if (neg_reg)
        begin
            over = (|quo_reg[QUO_BITS-1:DERIV_BITS])
                 | (quo_reg[DERIV_BITS-1] & (|quo_reg[DERIV_BITS-2:0]));
            mag  = over ? {1'b1, {(DERIV_BITS-1){1'b0}}} : quo_reg[DERIV_BITS-1:0];
        end
        else
        begin
            over = |quo_reg[QUO_BITS-1:DERIV_BITS-1];
            mag  = over ? {1'b0, {(DERIV_BITS-1){1'b1}}} : quo_reg[DERIV_BITS-1:0];
        end
        if (zero_reg)
            deriv_val = '0;
        else if (neg_reg)
            deriv_val = -$signed(mag);
        else
            deriv_val = $signed(mag);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_t_reg    <= time_stamp;
            in_v_reg    <= sample_value;
            in_last_reg <= last_sample;
        end
        if (cmd.shift)
        begin
            older_t_reg <= newer_t_reg;
            older_v_reg <= newer_v_reg;
            newer_t_reg <= in_t_reg;
            newer_v_reg <= in_v_reg;
        end
        if (cmd.diff)
        begin
            dy_reg <= DY_BITS'(in_v_reg) - DY_BITS'(ref_v);
            dt_reg <= $signed({1'b0, in_t_reg} - {1'b0, ref_t});
        end
        if (cmd.abs_load)
        begin
            neg_reg  <= dy_reg[DY_BITS-1] ^ dt_reg[DT_BITS-1];
            zero_reg <= (dt_reg == '0);
            dvs_reg  <= adt;
            rem_reg  <= '0;
            quo_reg  <= QUO_BITS'(ady) << FRAC_BITS;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? trial[DT_BITS-1:0] : shifted[DT_BITS-1:0];
            quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
        end
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                OUT_HELD:
                begin
                    value_reg <= newer_v_reg;
                    deriv_reg <= deriv_val;
                    err_reg   <= zero_reg;
                    last_reg  <= 1'b0;
                end
                OUT_FINAL:
                begin
                    value_reg <= in_v_reg;
                    deriv_reg <= deriv_val;
                    err_reg   <= zero_reg;
                    last_reg  <= 1'b1;
                end
                default:
                begin
                    value_reg <= in_v_reg;
                    deriv_reg <= '0;
                    err_reg   <= 1'b1;
                    last_reg  <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.last     = in_last_reg;
    assign status.out_free = ~out_valid_reg | ~out_stall;

    assign out_valid   = out_valid_reg;
    assign value_echo  = value_reg;
    assign derivative  = deriv_reg;
    assign div_error   = err_reg;
    assign last_result = last_reg;

endmodule

FILE: src/nfd_ctrl.sv
// controller: request sequencing, fill tracking and divider step count
`timescale 1ns / 1ps

module nfd_ctrl
    import nfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_ABS  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUO_BITS - 1);

    logic [2:0]          state_reg, state_next;
    logic [1:0]          fill_reg, fill_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    out_sel_t            sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.out_sel = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (fill_reg == 2'd0)
                begin
                    if (status.last)
                    begin
                        sel_next   = OUT_SINGLE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.shift  = 1'b1;
                        fill_next  = 2'd1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // forward difference for the first sample, central afterwards
                    cmd.diff    = 1'b1;
                    cmd.ref_sel = (fill_reg == 2'd1) ? REF_NEWER : REF_OLDER;
                    sel_next    = OUT_HELD;
                    state_next  = S_ABS;
                end
            end
            S_ABS:
            begin
                cmd.abs_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sel_reg == OUT_HELD && status.last)
                    begin
                        // backward difference for the final sample
                        cmd.diff    = 1'b1;
                        cmd.ref_sel = REF_NEWER;
                        sel_next    = OUT_FINAL;
                        state_next  = S_ABS;
                    end
                    else if (sel_reg == OUT_HELD)
                    begin
                        cmd.shift  = 1'b1;
                        fill_next  = 2'd2;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        fill_next  = 2'd0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= 2'd0;
            cnt_reg   <= '0;
            sel_reg   <= OUT_HELD;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: src/nonuniform_finite_difference_top.sv
// top level of the non-uniform grid derivative block
`timescale 1ns / 1ps

// Streams (time_stamp, sample_value) requests and returns, for each sample, its value and
// dy/dt in signed Q32.16, saturated to 48 bits; the first sample uses a forward difference,
// interior samples a central difference and the final sample (last_sample) a backward one.
// Results trail the input by one sample and the final sample releases two. A zero time step
// or a one-sample series gives derivative 0 with div_error set. Each quotient comes from a
// single restoring divider, one quotient bit per step, and the block takes no new sample
// before the one in work is through; a final sample holds the block for both of its results.
// A new result waits in the controller while a stalled one sits in the output register.
// in_stall is high while a sample is in work; a finished result waits in the output register
// without holding off the next request.

module nonuniform_finite_difference_top
    import nfd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [TIME_BITS-1:0]         time_stamp,
    input  logic signed [VALUE_BITS-1:0] sample_value,
    input  logic                         last_sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] value_echo,
    output logic signed [DERIV_BITS-1:0] derivative,
    output logic                         div_error,
    output logic                         last_result
);

    cmd_t    cmd;
    status_t status;

    nfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    nfd_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .time_stamp   (time_stamp),
        .sample_value (sample_value),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_echo   (value_echo),
        .derivative   (derivative),
        .div_error    (div_error),
        .last_result  (last_result)
    );

endmodule

FILE: src/nfd_checker.sv
// port-level checks for the derivative block, bound to the top level
`timescale 1ns / 1ps

module nfd_checker
    import nfd_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [TIME_BITS-1:0]         time_stamp,
    input logic signed [VALUE_BITS-1:0] sample_value,
    input logic                         last_sample,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [VALUE_BITS-1:0] value_echo,
    input logic signed [DERIV_BITS-1:0] derivative,
    input logic                         div_error,
    input logic                         last_result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_echo) && $stable(derivative)
            && $stable(div_error) && $stable(last_result))
        else $error("stalled result changed");

    // one request at a time: the block is busy right after a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while previous one in work");

    // an error result carries a zero derivative
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_error |-> derivative == '0)
        else $error("error result with nonzero derivative");

    // a held-off request keeps its payload until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(time_stamp) && $stable(sample_value)
            && $stable(last_sample))
        else $error("stalled request changed");

endmodule

bind nonuniform_finite_difference_top nfd_checker u_nfd_checker (.*);
